>>> rtl/core/bit_matrix_store_core_macros.svh
// assertion macros of the bit matrix store checker
`ifndef BIT_MATRIX_STORE_CORE_MACROS_SVH
`define BIT_MATRIX_STORE_CORE_MACROS_SVH

// same-cycle implication under the active-low reset
`define BMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit matrix store check failed");

// next-cycle implication under the active-low reset
`define BMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit matrix store check failed");

`endif

>>> rtl/core/bms_pkg.sv
// types and constants of the bit matrix store
package bms_pkg;

    localparam int MAX_DIM    = 256;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int BIT_IDX_W  = 5;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 9;
    localparam int PITCH_W    = 5;
    localparam int WD_W       = COORD_W - WORD_SHIFT;
    localparam int SUM_W      = COORD_W + 1;
    localparam int ADDR_WIDE_W = COORD_W + PITCH_W;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_SET    = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_FLIP   = 3'd3;
    localparam logic [2:0] CMD_REGION = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [8:0] region_width;
        logic [8:0] region_height;
    } in_item_t;

    typedef struct packed {
        logic bit_value;
        logic range_error;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SET,
        OP_GET,
        OP_FLIP,
        OP_FILL
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BIT_READ,
        ST_BIT_WRITE,
        ST_FILL,
        ST_FILL_LAST,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic step;
        logic sweep_start;
        logic sweep;
        logic capture;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_err;
        logic fill_last;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/core/bms_ctrl.sv
// controller state machine of the bit matrix store
module bms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cfg_write,
    input  bms_pkg::dp_status_t status,
    output bms_pkg::ctrl_cmd_t  cmd
);
    import bms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (cfg_write)
        begin
            // new dimension means a new, empty matrix
            state_next      = ST_INIT;
            cmd.sweep_start = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_INIT:
                begin
                    cmd.sweep = 1'b1;
                    if (status.sweep_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        if (status.in_err)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            unique case (status.op)
                                OP_CLEAR:
                                begin
                                    state_next      = ST_CLEAR;
                                    cmd.sweep_start = 1'b1;
                                end
                                OP_SET, OP_GET, OP_FLIP:
                                begin
                                    state_next = ST_BIT_READ;
                                end
                                OP_FILL:
                                begin
                                    state_next = ST_FILL;
                                end
                                default:
                                begin
                                    state_next = ST_DONE;
                                end
                            endcase
                        end
                    end
                end
                ST_BIT_READ:
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_BIT_WRITE;
                end
                ST_BIT_WRITE:
                begin
                    cmd.capture = 1'b1;
                    cmd.push    = status.out_free;
                    state_next  = status.out_free ? ST_IDLE : ST_DONE;
                end
                ST_FILL:
                begin
                    cmd.read = 1'b1;
                    cmd.step = 1'b1;
                    if (status.fill_last)
                    begin
                        state_next = ST_FILL_LAST;
                    end
                end
                ST_FILL_LAST:
                begin
                    // last word of the region is written in this cycle
                    cmd.capture = 1'b1;
                    cmd.push    = status.out_free;
                    state_next  = status.out_free ? ST_IDLE : ST_DONE;
                end
                ST_CLEAR:
                begin
                    cmd.sweep = 1'b1;
                    if (status.sweep_last)
                    begin
                        cmd.capture = 1'b1;
                        cmd.push    = status.out_free;
                        state_next  = status.out_free ? ST_IDLE : ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (status.out_free)
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/core/bms_datapath.sv
// datapath of the bit matrix store: word memory, address and mask logic, result register
module bms_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bms_pkg::in_item_t       in_data,
    input  logic                    cfg_valid,
    input  logic [8:0]              cfg_data,
    input  bms_pkg::ctrl_cmd_t      cmd,
    output bms_pkg::dp_status_t     status,
    input  logic                    out_ready,
    output logic                    out_valid,
    output bms_pkg::out_item_t      out_data
);
    import bms_pkg::*;

    localparam int MAX_PITCH     = (MAX_DIM + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_WORDS   = MAX_DIM * MAX_PITCH;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int RESET_DIM_I   = (MAX_DIM < 256) ? MAX_DIM : 256;
    localparam int RESET_PITCH_I = (RESET_DIM_I + WORD_BITS - 1) / WORD_BITS;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] store_mem [STORE_WORDS];

    logic [DIM_W-1:0]     dim_reg;
    logic [DIM_W-1:0]     dim_next;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [PITCH_W-1:0]   pitch_next;
    logic [ADDR_W-1:0]    sweep_cnt_reg;
    logic                 acc_pend_reg;
    logic                 out_valid_reg;

    op_t                  op_reg;
    logic [COORD_W-1:0]   y_reg;
    logic [COORD_W-1:0]   bottom_reg;
    logic [WD_W-1:0]      wd_reg;
    logic [WD_W-1:0]      first_reg;
    logic [WD_W-1:0]      last_reg;
    logic [BIT_IDX_W-1:0] lo_reg;
    logic [BIT_IDX_W-1:0] hi_reg;
    logic [ADDR_W-1:0]    acc_addr_reg;
    logic [WORD_BITS-1:0] acc_mask_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    out_item_t            res_reg;
    out_item_t            out_data_reg;

    op_t                  in_op;
    logic                 in_err;
    logic                 bit_err;
    logic                 region_err;
    logic [COORD_W-1:0]   in_col;
    logic [COORD_W-1:0]   in_row;
    logic [COORD_W-1:0]   in_right;
    logic [COORD_W-1:0]   in_bottom;
    logic [ADDR_WIDE_W-1:0] addr_wide;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] rd_mask;
    logic [WORD_BITS-1:0] acc_word;
    out_item_t            res_comb;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // configuration: saturate to the store size, derive the row pitch
    always_comb
    begin
        dim_next   = (int'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;
        pitch_next = PITCH_W'(dim_next[DIM_W-1:WORD_SHIFT])
                   + PITCH_W'(|dim_next[WORD_SHIFT-1:0]);
    end

    // decode and range check of the offered request
    always_comb
    begin
        unique case (in_data.cmd)
            CMD_CLEAR:  in_op = OP_CLEAR;
            CMD_SET:    in_op = OP_SET;
            CMD_GET:    in_op = OP_GET;
            CMD_FLIP:   in_op = OP_FLIP;
            CMD_REGION: in_op = OP_FILL;
            default:    in_op = OP_NONE;
        endcase
        in_col     = COORD_W'(in_data.col);
        in_row     = COORD_W'(in_data.row);
        in_right   = in_col + in_data.region_width - COORD_W'(1);
        in_bottom  = in_row + in_data.region_height - COORD_W'(1);
        bit_err    = (in_col >= dim_reg) || (in_row >= dim_reg);
        region_err = (in_data.region_width == '0) || (in_data.region_height == '0)
                  || ((SUM_W'(in_col) + SUM_W'(in_data.region_width)) > SUM_W'(dim_reg))
                  || ((SUM_W'(in_row) + SUM_W'(in_data.region_height)) > SUM_W'(dim_reg));
        unique case (in_op)
            OP_SET, OP_GET, OP_FLIP: in_err = bit_err;
            OP_FILL:                 in_err = region_err;
            default:                 in_err = 1'b0;
        endcase
    end

    // word address and masks of the current access
    always_comb
    begin
        addr_wide = ADDR_WIDE_W'(y_reg) * ADDR_WIDE_W'(pitch_reg) + ADDR_WIDE_W'(wd_reg);
        rd_addr   = ADDR_W'(addr_wide);
        bit_mask  = ONES & (WORD_BITS'(1) << lo_reg);
        lo_mask   = (wd_reg == first_reg) ? (ONES << lo_reg) : ONES;
        hi_mask   = (wd_reg == last_reg)
                  ? (ONES >> (BIT_IDX_W'(WORD_BITS - 1) - hi_reg)) : ONES;
        rd_mask   = (op_reg == OP_FILL) ? (lo_mask & hi_mask) : bit_mask;
        acc_word  = (op_reg == OP_FLIP) ? (rdata_reg ^ acc_mask_reg)
                                        : (rdata_reg | acc_mask_reg);
        res_comb.bit_value   = (op_reg == OP_GET) && (|(rdata_reg & acc_mask_reg));
        res_comb.range_error = 1'b0;
    end

    // write port: zeroing sweep or the modify half of a read-modify-write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = acc_addr_reg;
        mem_wdata = acc_word;
        if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else if (acc_pend_reg && (op_reg != OP_GET))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= DIM_W'(RESET_DIM_I);
            pitch_reg     <= PITCH_W'(RESET_PITCH_I);
            sweep_cnt_reg <= '0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dim_reg   <= dim_next;
                pitch_reg <= pitch_next;
            end
            if (cmd.sweep_start)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
            end
            acc_pend_reg <= cmd.read;
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            y_reg      <= in_row;
            bottom_reg <= in_bottom;
            wd_reg     <= WD_W'(in_data.col >> WORD_SHIFT);
            first_reg  <= WD_W'(in_data.col >> WORD_SHIFT);
            last_reg   <= in_right[COORD_W-1:WORD_SHIFT];
            lo_reg     <= in_data.col[BIT_IDX_W-1:0];
            hi_reg     <= in_right[BIT_IDX_W-1:0];
        end
        else if (cmd.step)
        begin
            // walk the region row by row, word by word
            if (wd_reg == last_reg)
            begin
                wd_reg <= first_reg;
                y_reg  <= y_reg + COORD_W'(1);
            end
            else
            begin
                wd_reg <= wd_reg + WD_W'(1);
            end
        end
        if (cmd.read)
        begin
            acc_addr_reg <= rd_addr;
            acc_mask_reg <= rd_mask;
        end
        if (cmd.load)
        begin
            res_reg.bit_value   <= 1'b0;
            res_reg.range_error <= in_err;
        end
        else if (cmd.capture)
        begin
            res_reg <= res_comb;
        end
        if (cmd.push)
        begin
            out_data_reg <= cmd.capture ? res_comb : res_reg;
        end
    end

    assign status.op         = in_op;
    assign status.in_err     = in_err;
    assign status.fill_last  = (wd_reg == last_reg) && (y_reg == bottom_reg);
    assign status.sweep_last = (sweep_cnt_reg == ADDR_W'(STORE_WORDS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/bit_matrix_store_core.sv
// top level of the bit matrix store
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    in_data (cmd, col, row, region size)
//  out      out        out_valid / out_ready  out_data (bit_value, range_error)
//  cfg      in         cfg_valid / cfg_ready  cfg_data (dimension)
//
// set, get and flip: accept, one memory read, then the write and the result
// set region: one word read-modify-write per cycle
// clear: the whole store is zeroed, one word per cycle
// rejected or unused commands: accept, then the result, with no memory access
// after reset and after each dimension write a zeroing pass over the whole store
// runs with in_ready low; a held result stalls only the next finish
module bit_matrix_store_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bms_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bms_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import bms_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // dimension writes are to arrive only while idle (the user's duty, not enforced here); they never wait
    assign cfg_ready = 1'b1;

    bms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_write (cfg_valid),
        .status    (status),
        .cmd       (cmd)
    );

    bms_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/bms_checker.sv
// port-level assertions of the bit matrix store, bound to the top level
`include "bit_matrix_store_core_macros.svh"

module bms_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input bms_pkg::out_item_t out_data,
    input logic               cfg_valid
);
    import bms_pkg::*;

    // a held result keeps its value
    `BMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data))

    // one request at a time: ready drops right after an accepted request
    `BMS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // a dimension write starts the zeroing pass, no request taken meanwhile
    `BMS_ASSERT_NEXT(a_cfg_blocks, clk, rst_n, cfg_valid, !in_ready)

    // a rejected request never reports a bit
    `BMS_ASSERT_IMP(a_err_no_bit, clk, rst_n, out_valid,
        !(out_data.bit_value && out_data.range_error))

endmodule

bind bit_matrix_store_core bms_checker u_bms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid)
);
